// ===== design/assert_macros.svh =====
// Shared assertion macros; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ===== design/pmb_pkg.sv =====
package pmb_pkg;

  // level conversion
  localparam int NORM_W        = 32;
  localparam int MANT_W        = 31;
  localparam int FRAC_W        = 16;
  localparam int DB_W          = 16;
  localparam int OUT_DB_W      = 15;
  localparam int DB_PER_LOG2_W = 26;
  localparam logic [DB_PER_LOG2_W-1:0] DB_PER_LOG2 = 26'd50504453;

  localparam int DB_MIN   = -16384;
  localparam int DB_MAX   = 768;
  localparam int DB_RESET = -15360;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FALL_STEP      = 3'd0,
    REG_HOLD_FALL_STEP = 3'd1,
    REG_HOLD_FRAMES    = 3'd2,
    REG_OVER_FRAMES    = 3'd3,
    REG_SILENCE_FLOOR  = 3'd4,
    REG_HOLD_MODE      = 3'd5
  } cfg_idx_e;

  localparam logic [1:0] HOLD_NONE    = 2'd0;
  localparam logic [1:0] HOLD_DYNAMIC = 2'd1;

  localparam logic [9:0]         FALL_STEP_RST      = 10'd60;
  localparam logic [9:0]         HOLD_FALL_STEP_RST = 10'd72;
  localparam logic [9:0]         HOLD_FRAMES_RST    = 10'd25;
  localparam logic [3:0]         OVER_FRAMES_RST    = 4'd2;
  localparam logic signed [14:0] SILENCE_FLOOR_RST  = -15'sd8960;
  localparam logic [1:0]         HOLD_MODE_RST      = 2'd1;

  typedef struct packed {
    logic [9:0]         fall_step;
    logic [9:0]         hold_fall_step;
    logic [9:0]         hold_frames;
    logic [3:0]         over_frames;
    logic signed [14:0] silence_floor;
    logic [1:0]         hold_mode;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQR,
    ST_MAG,
    ST_MUL,
    ST_RND,
    ST_UPD1,
    ST_UPD2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic square;
    logic first;
    logic mag;
    logic mul;
    logic round;
    logic upd1;
    logic upd2;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic norm_done;
  } sts_t;

endpackage

// ===== design/pmb_if.sv =====
interface pmb_in_if #(
  parameter int LEVEL_BITS = 24
) ();
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] peak_level;

  modport source (output valid, output peak_level, input ready);
  modport sink   (input valid, input peak_level, output ready);
endinterface

interface pmb_out_if ();
  logic                                 valid;
  logic                                 ready;
  logic signed [pmb_pkg::OUT_DB_W-1:0]  meter_db;
  logic signed [pmb_pkg::OUT_DB_W-1:0]  hold_db;
  logic                                 hold_shown;
  logic                                 over_led;

  modport source (output valid, output meter_db, output hold_db, output hold_shown,
                  output over_led, input ready);
  modport sink   (input valid, input meter_db, input hold_db, input hold_shown,
                  input over_led, output ready);
endinterface

interface pmb_cfg_if ();
  logic                             valid;
  logic                             ready;
  logic [pmb_pkg::CFG_IDX_W-1:0]    index;
  logic [pmb_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pmb_cfg.sv =====
module pmb_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_valid_i,
  output logic                             wr_ready_o,
  input  logic [pmb_pkg::CFG_IDX_W-1:0]    wr_index_i,
  input  logic [pmb_pkg::CFG_DATA_W-1:0]   wr_data_i,
  output pmb_pkg::cfg_t                    cfg_o
);

  pmb_pkg::cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        pmb_pkg::REG_FALL_STEP:      cfg_d.fall_step      = wr_data_i[9:0];
        pmb_pkg::REG_HOLD_FALL_STEP: cfg_d.hold_fall_step = wr_data_i[9:0];
        pmb_pkg::REG_HOLD_FRAMES:    cfg_d.hold_frames    = wr_data_i[9:0];
        pmb_pkg::REG_OVER_FRAMES:    cfg_d.over_frames    = wr_data_i[3:0];
        pmb_pkg::REG_SILENCE_FLOOR:  cfg_d.silence_floor  = signed'(wr_data_i[14:0]);
        pmb_pkg::REG_HOLD_MODE:      cfg_d.hold_mode      = wr_data_i[1:0];
        default:                     cfg_d = cfg_q;  // drop writes past the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fall_step      <= pmb_pkg::FALL_STEP_RST;
      cfg_q.hold_fall_step <= pmb_pkg::HOLD_FALL_STEP_RST;
      cfg_q.hold_frames    <= pmb_pkg::HOLD_FRAMES_RST;
      cfg_q.over_frames    <= pmb_pkg::OVER_FRAMES_RST;
      cfg_q.silence_floor  <= pmb_pkg::SILENCE_FLOOR_RST;
      cfg_q.hold_mode      <= pmb_pkg::HOLD_MODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== design/pmb_ctrl.sv =====
module pmb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pmb_pkg::sts_t sts_i,
  output pmb_pkg::cmd_t cmd_o
);

  localparam logic [3:0] RndLast = 4'(pmb_pkg::FRAC_W - 1);

  pmb_pkg::state_e state_q, state_d;
  logic [3:0]      rnd_q, rnd_d;
  logic            out_valid_q, out_valid_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pmb_pkg::ST_IDLE: if (in_valid_i) state_d = pmb_pkg::ST_NORM;
      pmb_pkg::ST_NORM: begin
        if (sts_i.zero) begin
          state_d = pmb_pkg::ST_UPD1;
        end else if (sts_i.norm_done) begin
          state_d = pmb_pkg::ST_SQR;
        end
      end
      pmb_pkg::ST_SQR:  if (rnd_q == RndLast) state_d = pmb_pkg::ST_MAG;
      pmb_pkg::ST_MAG:  state_d = pmb_pkg::ST_MUL;
      pmb_pkg::ST_MUL:  state_d = pmb_pkg::ST_RND;
      pmb_pkg::ST_RND:  state_d = pmb_pkg::ST_UPD1;
      pmb_pkg::ST_UPD1: state_d = pmb_pkg::ST_UPD2;
      pmb_pkg::ST_UPD2: state_d = pmb_pkg::ST_OUT;
      pmb_pkg::ST_OUT:  if (!out_valid_q || out_ready_i) state_d = pmb_pkg::ST_IDLE;
      default:          state_d = pmb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pmb_pkg::ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      pmb_pkg::ST_NORM: cmd_o.shift = !sts_i.zero && !sts_i.norm_done;
      pmb_pkg::ST_SQR: begin
        cmd_o.square = 1'b1;
        cmd_o.first  = (rnd_q == '0);
      end
      pmb_pkg::ST_MAG:  cmd_o.mag   = 1'b1;
      pmb_pkg::ST_MUL:  cmd_o.mul   = 1'b1;
      pmb_pkg::ST_RND:  cmd_o.round = 1'b1;
      pmb_pkg::ST_UPD1: cmd_o.upd1  = 1'b1;
      pmb_pkg::ST_UPD2: cmd_o.upd2  = 1'b1;
      pmb_pkg::ST_OUT:  cmd_o.out_load = !out_valid_q || out_ready_i;
      default:          cmd_o = '0;
    endcase
  end

  assign rnd_d       = (state_q == pmb_pkg::ST_SQR) ? rnd_q + 4'd1 : '0;
  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pmb_pkg::ST_IDLE;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/pmb_datapath.sv =====
`include "assert_macros.svh"

module pmb_datapath #(
  parameter int LEVEL_BITS = 24,
  parameter int DB_BITS    = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pmb_pkg::cfg_t                        cfg_i,
  input  pmb_pkg::cmd_t                        cmd_i,
  output pmb_pkg::sts_t                        sts_o,
  input  logic [LEVEL_BITS-1:0]                level_i,
  output logic signed [pmb_pkg::OUT_DB_W-1:0]  meter_db_o,
  output logic signed [pmb_pkg::OUT_DB_W-1:0]  hold_db_o,
  output logic                                 hold_shown_o,
  output logic                                 over_led_o
);

  localparam int KW    = $clog2(LEVEL_BITS);
  localparam int MagW  = KW + pmb_pkg::FRAC_W;
  localparam int ProdW = MagW + pmb_pkg::DB_PER_LOG2_W;
  localparam int RndW  = ProdW - 31;
  localparam int DbW   = pmb_pkg::DB_W;
  localparam int CmpW  = (DB_BITS > DbW ? DB_BITS : DbW) + 2;
  localparam int MW    = pmb_pkg::MANT_W;
  localparam int NW    = pmb_pkg::NORM_W;

  localparam logic signed [RndW:0]  RMinC   = (RndW+1)'(pmb_pkg::DB_MIN);
  localparam logic signed [RndW:0]  RMaxC   = (RndW+1)'(pmb_pkg::DB_MAX);
  localparam logic signed [DbW-1:0] DbMinC  = DbW'(pmb_pkg::DB_MIN);
  localparam logic signed [DbW-1:0] DbMaxC  = DbW'(pmb_pkg::DB_MAX);
  localparam logic signed [CmpW-1:0] ResetC = CmpW'(pmb_pkg::DB_RESET);
  localparam logic [ProdW:0]        HalfC   = (ProdW+1)'(64'd1 << 32) >> 1;

  // conversion working registers
  logic [NW-1:0]          x_q;
  logic [KW-1:0]          k_q;
  logic                   zero_q, ovr_q, sil_q;
  logic [MW-1:0]          y_q;
  logic [pmb_pkg::FRAC_W-1:0] frac_q;
  logic [MagW-1:0]        mag_q;
  logic                   neg_q;
  logic [ProdW-1:0]       prod_q;
  logic signed [DbW-1:0]  db_q;

  // meter state
  logic signed [DB_BITS-1:0] shown_q, hold_q;
  logic                      falling_q, led_q;
  logic [9:0]                timer_q;
  logic [3:0]                ocnt_q;

  // result register
  logic signed [pmb_pkg::OUT_DB_W-1:0] meter_q, holdo_q;
  logic                                shown_flag_q, led_out_q;

  assign sts_o.zero      = zero_q;
  assign sts_o.norm_done = x_q[NW-1];

  // squaring round: one 31x31 product, renormalize by at most one bit
  logic [MW-1:0]     sq_op;
  logic [2*MW-1:0]   sq;
  logic [NW-1:0]     sq_t;
  logic              sq_bit;
  logic [MW-1:0]     y_next;

  assign sq_op  = cmd_i.first ? x_q[NW-1:1] : y_q;
  assign sq     = sq_op * sq_op;
  assign sq_t   = sq[2*MW-1:MW-1];
  assign sq_bit = sq_t[NW-1];
  assign y_next = sq_bit ? sq_t[NW-1:1] : sq_t[MW-1:0];

  // log2 magnitude: integer part is 1 - k
  logic [KW-1:0]   k_m1;
  logic [MagW-1:0] mag_pos, mag_neg;
  assign k_m1    = k_q - KW'(1);
  assign mag_pos = {KW'(k_q == '0), frac_q};
  assign mag_neg = {k_m1, {pmb_pkg::FRAC_W{1'b0}}} - MagW'(frac_q);

  // round to nearest, apply sign, saturate
  logic [ProdW:0]        rsum;
  logic signed [RndW:0]  rabs, rsgn, rclamp;
  assign rsum   = {1'b0, prod_q} + HalfC;
  assign rabs   = signed'({1'b0, rsum[ProdW:32]});
  assign rsgn   = neg_q ? -rabs : rabs;
  assign rclamp = (rsgn < RMinC) ? RMinC : ((rsgn > RMaxC) ? RMaxC : rsgn);

  // ballistics, first half
  logic signed [CmpW-1:0] sh_x, ho_x, db_x, diff, fall_x, hfall_x, floor_x;
  logic signed [CmpW-1:0] shown_nx, hold_nx;
  logic                   silent;
  logic [3:0]             oc1;
  assign sh_x    = CmpW'(shown_q);
  assign ho_x    = CmpW'(hold_q);
  assign db_x    = CmpW'(db_q);
  assign fall_x  = signed'(CmpW'(cfg_i.fall_step));
  assign hfall_x = signed'(CmpW'(cfg_i.hold_fall_step));
  assign floor_x = CmpW'(cfg_i.silence_floor);
  assign diff    = sh_x - db_x;
  assign shown_nx = (diff > fall_x) ? (sh_x - fall_x) : db_x;
  assign hold_nx  = (falling_q && (ho_x >= ResetC)) ? (ho_x - hfall_x) : ho_x;
  assign silent   = zero_q && (sh_x <= floor_x);
  assign oc1      = ovr_q ? ocnt_q + 4'd1 : 4'd0;

  // ballistics, second half: new hold value and hold timer
  logic       new_hold, dyn, restart;
  logic [9:0] t1;
  assign new_hold = !sil_q && (hold_q <= shown_q);
  assign dyn      = (cfg_i.hold_mode == pmb_pkg::HOLD_DYNAMIC);
  assign restart  = new_hold && dyn;
  assign t1       = timer_q + 10'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= NW'(level_i) << (NW - LEVEL_BITS);
      k_q    <= '0;
      zero_q <= (level_i == '0);
      ovr_q  <= |level_i[LEVEL_BITS-1 -: 2];
      frac_q <= '0;
      db_q   <= DbMinC;
    end
    if (cmd_i.shift) begin
      x_q <= {x_q[NW-2:0], 1'b0};
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.square) begin
      y_q    <= y_next;
      frac_q <= {frac_q[pmb_pkg::FRAC_W-2:0], sq_bit};
    end
    if (cmd_i.mag) begin
      neg_q <= (k_q > KW'(1));
      mag_q <= (k_q > KW'(1)) ? mag_neg : mag_pos;
    end
    if (cmd_i.mul) begin
      prod_q <= mag_q * pmb_pkg::DB_PER_LOG2;
    end
    if (cmd_i.round) begin
      db_q <= DbW'(rclamp);
    end
    if (cmd_i.upd1) begin
      sil_q <= silent;
    end
    if (cmd_i.out_load) begin
      meter_q      <= sh_x[pmb_pkg::OUT_DB_W-1:0];
      holdo_q      <= ho_x[pmb_pkg::OUT_DB_W-1:0];
      shown_flag_q <= (cfg_i.hold_mode != pmb_pkg::HOLD_NONE);
      led_out_q    <= led_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q   <= ResetC[DB_BITS-1:0];
      hold_q    <= ResetC[DB_BITS-1:0];
      falling_q <= 1'b0;
      timer_q   <= '0;
      ocnt_q    <= '0;
      led_q     <= 1'b0;
    end else begin
      if (cmd_i.upd1) begin
        if (silent) begin
          hold_q <= ResetC[DB_BITS-1:0];
          led_q  <= 1'b0;
        end else begin
          shown_q <= shown_nx[DB_BITS-1:0];
          hold_q  <= hold_nx[DB_BITS-1:0];
          if (oc1 >= cfg_i.over_frames) begin
            led_q  <= 1'b1;
            ocnt_q <= '0;
          end else begin
            ocnt_q <= oc1;
          end
        end
      end
      if (cmd_i.upd2) begin
        if (new_hold) begin
          falling_q <= 1'b0;
          hold_q    <= shown_q;
        end
        if (restart) begin
          timer_q <= '0;
        end else if (dyn) begin
          if (t1 >= cfg_i.hold_frames) begin
            falling_q <= 1'b1;
            timer_q   <= '0;
          end else begin
            timer_q <= t1;
          end
        end
      end
    end
  end

  assign meter_db_o   = meter_q;
  assign hold_db_o    = holdo_q;
  assign hold_shown_o = shown_flag_q;
  assign over_led_o   = led_out_q;

  `ASSERT_NEVER(a_shift_guard, clk_i, rst_ni, cmd_i.shift && (x_q[NW-1] || zero_q), "shift past normalized or zero level")
  `ASSERT_PROP(a_db_range, clk_i, rst_ni, cmd_i.round |=> (db_q >= DbMinC && db_q <= DbMaxC), "converted level out of range")
  `ASSERT_PROP(a_mant_norm, clk_i, rst_ni, cmd_i.square |=> y_q[MW-1], "squaring mantissa lost normalization")

endmodule

// ===== design/peak_meter_ballistics.sv =====
// A zero item skips the log conversion. Any other item's time grows with z, the
// leading zeros of peak_level (0 .. LEVEL_BITS-1), through the one-bit-a-cycle
// normalizer, and it also takes 16 squaring rounds on a single 31x31 multiplier.
// Items go one at a time: a new level is taken once the last result is loaded.
// Reset (rst_ni low, async): registers to defaults, shown and hold levels to -120 dB,
// over count, hold timer and LED cleared, no result pending.
module peak_meter_ballistics #(
  parameter int LEVEL_BITS = 24,
  parameter int DB_BITS    = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmb_in_if.sink     in_i,
  pmb_out_if.source  out_o,
  pmb_cfg_if.sink    cfg_i
);

  // Flow per item: latch the level, normalize it one bit per cycle, square the
  // mantissa 16 times for the log2 fraction, scale by 20*log10(2) in a single
  // multiply, round and saturate (a zero level skips these), then the meter
  // ballistics (fall limiting and over count; then peak hold and hold timer), and
  // load the result register. The input side is open again while a result waits.

  pmb_pkg::cfg_t cfg;
  pmb_pkg::cmd_t cmd;
  pmb_pkg::sts_t sts;

  // Configuration registers; writes are taken every cycle.
  pmb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Sequencer: one item in flight, result held until taken.
  pmb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Log conversion, ballistics state and the result register.
  pmb_datapath #(
    .LEVEL_BITS (LEVEL_BITS),
    .DB_BITS    (DB_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .level_i      (in_i.peak_level),
    .meter_db_o   (out_o.meter_db),
    .hold_db_o    (out_o.hold_db),
    .hold_shown_o (out_o.hold_shown),
    .over_led_o   (out_o.over_led)
  );

endmodule
